[design/ple_pkg.sv]
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared types and sizes for the ordered list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 7;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_LIST   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_INS_PUT,
    ST_SHIFT_DN,
    ST_LIST,
    ST_RESP
  } state_e;

  typedef struct packed {
    req_e                    req_type;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        item_position;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic [POS_W-1:0]        out_index;
    status_e                 status;
    logic                    last_result;
  } rsp_t;

endpackage

[design/positional_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values with append, insert, delete, list and
// clear requests, held in a single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_valid_i / in_data_i and are taken when
// in_stall_o is low. Results leave on out_valid_o / out_data_o and are
// taken when out_stall_i is low. One request is worked on at a time, and
// in_stall_o stays high until its last result sits in the output register.
// Append, clear and refused requests give one result through the response
// state. Insert moves entries up one place per cycle through the memory
// port, then writes the new value at its position. Delete moves entries
// down likewise. Listing reads one entry per cycle while the receiver does
// not stall and emits count results; an empty list gives one result. The
// memory port allows one read and one write per cycle. A stalled receiver
// holds the output register, and the sequencer waits on it, so no result
// is lost. Reset empties the list and the output register; memory contents
// are left. Unused request types are taken and give no result.
// ----------------------------------------------------------------------------
module positional_list_engine_unit
  import ple_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [VAL_W-1:0]  val_q, val_d;
  status_e           st_q, st_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;
  logic              out_load;

  logic [VAL_W-1:0]  mem_q [CAPACITY];
  logic [VAL_W-1:0]  mem_rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [VAL_W-1:0]  mem_wdata;

  logic              in_accept, out_free;
  logic [CNT_W-1:0]  ptr_ext, pos_ext, ipos_ext, ins_pos;
  logic              is_add, ins_bad, is_full, ins_tail, del_bad, del_tail;
  logic              up_done, dn_done, list_last;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign ptr_ext  = CNT_W'(ptr_q);
  assign pos_ext  = CNT_W'(pos_q);
  assign ipos_ext = CNT_W'(in_data_i.item_position);

  // Append is an insert at the current count.
  assign is_add   = (in_data_i.req_type == REQ_APPEND) || (in_data_i.req_type == REQ_INSERT);
  assign ins_pos  = (in_data_i.req_type == REQ_APPEND) ? cnt_q : ipos_ext;
  assign ins_bad  = ins_pos > cnt_q;
  assign is_full  = cnt_q >= CNT_W'(CAPACITY);
  assign ins_tail = ins_pos == cnt_q;
  assign del_bad  = ipos_ext >= cnt_q;
  assign del_tail = (ipos_ext + CNT_W'(1)) == cnt_q;

  assign up_done   = ptr_ext == (pos_ext + CNT_W'(1));
  assign dn_done   = (ptr_ext + CNT_W'(2)) == cnt_q;
  assign list_last = (ptr_ext + CNT_W'(1)) == cnt_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          priority if (is_add) begin
            if (ins_bad || is_full || ins_tail) state_d = ST_RESP;
            else                                state_d = ST_SHIFT_UP;
          end else if (in_data_i.req_type == REQ_DELETE) begin
            if (del_bad || del_tail) state_d = ST_RESP;
            else                     state_d = ST_SHIFT_DN;
          end else if (in_data_i.req_type == REQ_LIST) begin
            if (cnt_q == '0) state_d = ST_RESP;
            else             state_d = ST_LIST;
          end else if (in_data_i.req_type == REQ_CLEAR) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SHIFT_UP: if (up_done) state_d = ST_INS_PUT;
      ST_INS_PUT:  state_d = ST_RESP;
      ST_SHIFT_DN: if (dn_done) state_d = ST_RESP;
      ST_LIST:     if (out_free && list_last) state_d = ST_IDLE;
      ST_RESP:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    val_d     = val_q;
    st_d      = st_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ptr_q;
    mem_raddr = ptr_q;
    mem_wdata = mem_rdata_q;
    out_load  = 1'b0;
    out_d     = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          st_d  = STAT_OK;
          val_d = in_data_i.item_value;
          pos_d = in_data_i.item_position[ADDR_W-1:0];
          priority if (is_add) begin
            priority if (ins_bad) begin
              st_d = STAT_BADPOS;
            end else if (is_full) begin
              st_d = STAT_FULL;
            end else if (ins_tail) begin
              mem_we    = 1'b1;
              mem_waddr = ins_pos[ADDR_W-1:0];
              mem_wdata = in_data_i.item_value;
              cnt_d     = cnt_q + CNT_W'(1);
            end else begin
              // Start moving the tail up: read the last entry first.
              mem_re    = 1'b1;
              mem_raddr = ADDR_W'(cnt_q - CNT_W'(1));
              ptr_d     = cnt_q[ADDR_W-1:0];
            end
          end else if (in_data_i.req_type == REQ_DELETE) begin
            priority if (del_bad) begin
              st_d = STAT_BADPOS;
            end else if (del_tail) begin
              cnt_d = cnt_q - CNT_W'(1);
            end else begin
              mem_re    = 1'b1;
              mem_raddr = ADDR_W'(ipos_ext + CNT_W'(1));
              ptr_d     = in_data_i.item_position[ADDR_W-1:0];
            end
          end else if (in_data_i.req_type == REQ_LIST) begin
            if (cnt_q == '0) begin
              st_d = STAT_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              ptr_d     = '0;
            end
          end else if (in_data_i.req_type == REQ_CLEAR) begin
            cnt_d = '0;
          end else begin
            // Unused request types leave the list as it is.
            cnt_d = cnt_q;
          end
        end
      end
      ST_SHIFT_UP: begin
        // Write the entry read last cycle one place higher, and read the next.
        mem_we = 1'b1;
        if (!up_done) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(ptr_ext - CNT_W'(2));
          ptr_d     = ADDR_W'(ptr_ext - CNT_W'(1));
        end
      end
      ST_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
        cnt_d     = cnt_q + CNT_W'(1);
      end
      ST_SHIFT_DN: begin
        mem_we = 1'b1;
        if (dn_done) begin
          cnt_d = cnt_q - CNT_W'(1);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(ptr_ext + CNT_W'(2));
          ptr_d     = ADDR_W'(ptr_ext + CNT_W'(1));
        end
      end
      ST_LIST: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.out_value   = mem_rdata_q;
          out_d.out_index   = POS_W'(ptr_q);
          out_d.status      = STAT_OK;
          out_d.last_result = list_last;
          if (!list_last) begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(ptr_ext + CNT_W'(1));
            ptr_d     = ADDR_W'(ptr_ext + CNT_W'(1));
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.out_value   = '0;
          out_d.out_index   = '0;
          out_d.status      = st_q;
          out_d.last_result = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    pos_q <= pos_d;
    val_q <= val_d;
    st_q  <= st_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) mem_rdata_q <= mem_q[mem_raddr];
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A new result never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  // Listing only walks valid entries.
  a_list_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |-> (ptr_ext < cnt_q))
    else $error("list pointer beyond count");

  // An upward shift stays between the insert position and the count.
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT_UP) |-> (ptr_ext > pos_ext && ptr_ext <= cnt_q))
    else $error("shift pointer out of range");

endmodule
